/* hdl/mecanum_odometry_integrator_top_defines.svh */
// assertion macros for the mecanum odometry integrator
`ifndef MECANUM_ODOMETRY_INTEGRATOR_TOP_DEFINES_SVH
`define MECANUM_ODOMETRY_INTEGRATOR_TOP_DEFINES_SVH

// next-cycle implication, disabled while reset is held
`define MOI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("moi assertion failed");

// next-cycle implication that also runs through reset
`define MOI_ASSERT_NEXT_NR(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("moi reset assertion failed");

`endif

/* hdl/moi_pkg.sv */
// shared constants and tables for the mecanum odometry integrator
`default_nettype none
package moi_pkg;
    localparam int TICK_WIDTH_DEF = 16;
    localparam int POS_WIDTH_DEF  = 40;
    localparam int DPT_W          = 24;
    localparam logic [DPT_W-1:0] DPT_RESET = 24'd167772;
    localparam int HEAD_W         = 17;
    localparam int FULL_TURN      = 36000;
    localparam int TURN_W         = $clog2(FULL_TURN);
    localparam int ANG_W          = 32;
    localparam int TRIG_W         = 34;
    localparam int CORDIC_STEPS   = 24;
    localparam int STEP_IW        = $clog2(CORDIC_STEPS);
    localparam int CORDIC_GAIN    = 652032874;
    localparam int FRAC_SHIFT     = 30;
    localparam int ROUND_SHIFT    = 10;
    localparam int ROUND_BIAS     = 512;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;
    localparam logic REG_DPT      = 1'b0;

    // arctangent of 2^-i in binary angle units, one turn is 2^32
    function automatic logic signed [TRIG_W-1:0] moi_atan(input logic [STEP_IW-1:0] i);
        logic signed [TRIG_W-1:0] r;
        case (i)
            0:  r = TRIG_W'(536870912);
            1:  r = TRIG_W'(316933406);
            2:  r = TRIG_W'(167458907);
            3:  r = TRIG_W'(85004756);
            4:  r = TRIG_W'(42667331);
            5:  r = TRIG_W'(21354465);
            6:  r = TRIG_W'(10679838);
            7:  r = TRIG_W'(5340245);
            8:  r = TRIG_W'(2670163);
            9:  r = TRIG_W'(1335087);
            10: r = TRIG_W'(667544);
            11: r = TRIG_W'(333772);
            12: r = TRIG_W'(166886);
            13: r = TRIG_W'(83443);
            14: r = TRIG_W'(41722);
            15: r = TRIG_W'(20861);
            16: r = TRIG_W'(10430);
            17: r = TRIG_W'(5215);
            18: r = TRIG_W'(2608);
            19: r = TRIG_W'(1304);
            20: r = TRIG_W'(652);
            21: r = TRIG_W'(326);
            22: r = TRIG_W'(163);
            23: r = TRIG_W'(81);
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

/* hdl/moi_mul.sv */
// bit-serial signed shift-add multiplier, one multiplier bit per cycle
`default_nettype none
module moi_mul #(
    parameter int AW = 18,
    parameter int BW = 25
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      start,
    input  wire signed [AW-1:0]      a,
    input  wire        [BW-1:0]      b,
    output logic                     done,
    output logic signed [AW+BW-1:0]  product
);
    localparam int CW = $clog2(BW);

    logic signed [AW-1:0] a_reg;
    logic [BW-1:0]        b_reg;
    logic signed [AW:0]   hi_reg;
    logic [BW-1:0]        lo_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic                 last;
    logic signed [AW+1:0] addend;
    logic signed [AW+1:0] sum_next;
    logic [AW+BW:0]       full;

    // the sign bit of b carries negative weight
    assign last     = (cnt_reg == CW'(BW-1));
    assign addend   = !b_reg[0] ? '0 : (last ? -(AW+2)'(a_reg) : (AW+2)'(a_reg));
    assign sum_next = (AW+2)'(hi_reg) + addend;
    assign full     = {hi_reg, lo_reg};
    assign product  = signed'(full[AW+BW-1:0]);
    assign done     = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= a;
                b_reg    <= b;
                hi_reg   <= '0;
                lo_reg   <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                hi_reg  <= sum_next[AW+1:1];
                lo_reg  <= {sum_next[0], lo_reg[BW-1:1]};
                b_reg   <= b_reg >> 1;
                cnt_reg <= cnt_reg + CW'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/moi_div.sv */
// restoring divider: binary angle = m * 2^32 / 36000, one quotient bit per cycle
`default_nettype none
module moi_div import moi_pkg::*; (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               start,
    input  wire  [TURN_W-1:0] m,
    output logic              done,
    output logic [ANG_W-1:0]  bam
);
    localparam int CW = $clog2(ANG_W);

    logic [TURN_W-1:0] r_reg;
    logic [ANG_W-1:0]  q_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [TURN_W:0]   r2;
    logic              ge;
    logic [TURN_W:0]   r_sub;

    assign r2    = {r_reg, 1'b0};
    assign ge    = (r2 >= (TURN_W+1)'(FULL_TURN));
    assign r_sub = r2 - (TURN_W+1)'(FULL_TURN);
    assign done  = done_reg;
    assign bam   = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                r_reg    <= m;
                q_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                r_reg   <= ge ? r_sub[TURN_W-1:0] : r2[TURN_W-1:0];
                q_reg   <= {q_reg[ANG_W-2:0], ge};
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(ANG_W-1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/moi_cordic.sv */
// iterative rotation-mode cordic, one micro-rotation per cycle
`default_nettype none
module moi_cordic import moi_pkg::*; (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      start,
    input  wire  [ANG_W-1:0]         bam,
    output logic                     done,
    output logic signed [TRIG_W-1:0] cos_out,
    output logic signed [TRIG_W-1:0] sin_out
);
    logic signed [TRIG_W-1:0] x_reg, y_reg, z_reg;
    logic [STEP_IW-1:0]       i_reg;
    logic                     flip_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic signed [TRIG_W-1:0] xs, ys, atan_i, x_next, y_next, z_next;
    logic                     flip_in;
    logic                     last;

    // second and third quadrant fold by half a turn
    assign flip_in = bam[ANG_W-1] ^ bam[ANG_W-2];
    assign xs      = x_reg >>> i_reg;
    assign ys      = y_reg >>> i_reg;
    assign atan_i  = moi_atan(i_reg);
    assign last    = (i_reg == STEP_IW'(CORDIC_STEPS-1));
    assign done    = done_reg;
    assign cos_out = x_reg;
    assign sin_out = y_reg;

    always_comb begin
        if (!z_reg[TRIG_W-1]) begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_i;
        end else begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= TRIG_W'(CORDIC_GAIN);
                y_reg    <= '0;
                z_reg    <= TRIG_W'(signed'({bam[ANG_W-1] ^ flip_in, bam[ANG_W-2:0]}));
                flip_reg <= flip_in;
                i_reg    <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                z_reg <= z_next;
                i_reg <= i_reg + STEP_IW'(1);
                if (last) begin
                    x_reg    <= flip_reg ? -x_next : x_next;
                    y_reg    <= flip_reg ? -y_next : y_next;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    x_reg <= x_next;
                    y_reg <= y_next;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/mecanum_odometry_integrator_top.sv */
// top level of the mecanum wheel odometry integrator with gyro heading
//
//  channel  | direction | beat contents (low bits first)
//  s_       | in        | tuser: opcode; tdata: fl, fr, rl, rr ticks, heading
//  m_       | out       | tdata: x_position, y_position, saturated
//  apb      | cfg       | register 0 at byte 0: distance_per_tick
//
// an integrate beat passes through heading wrap, the bit-serial angle divider
// (wheel scaling runs beside it), the 24 cordic micro-rotations, the four
// serial multiplier lanes and a last step to round, sum and clip into the
// output register
// a clear beat goes straight to the sum step; the input reopens as soon as a
// result is registered, so one beat is worked on at a time
// a finished result waits in the output register while the next beat enters;
// a result still waiting there holds the next beat in the sum step
// aresetn is synchronous; it zeroes the position and reloads the register
`default_nettype none
module mecanum_odometry_integrator_top import moi_pkg::*; #(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF,
    parameter int POS_WIDTH  = POS_WIDTH_DEF,
    localparam int IN_DW  = ((4*TICK_WIDTH + HEAD_W + 7) / 8) * 8,
    localparam int OUT_DW = ((2*POS_WIDTH + 1 + 7) / 8) * 8
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_tvalid,
    output logic               s_tready,
    input  wire  [IN_DW-1:0]   s_tdata,   // fl, fr, rl, rr ticks, heading_centideg
    input  wire  [0:0]         s_tuser,   // opcode
    output logic               m_tvalid,
    input  wire                m_tready,
    output logic [OUT_DW-1:0]  m_tdata,   // x_position, y_position, saturated
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [APB_AW-1:0]  paddr,
    input  wire  [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);
    localparam int SUM_W  = TICK_WIDTH + 2;
    localparam int SCL_BW = DPT_W + 1;
    localparam int FW     = SUM_W + SCL_BW;
    localparam int PW     = FW + TRIG_W;
    localparam int PRW    = PW - FRAC_SHIFT;
    localparam int DXW    = PRW + 1;
    localparam int SW     = ((POS_WIDTH > DXW) ? POS_WIDTH : DXW) + 1;
    localparam int HM_W   = HEAD_W + 1;
    localparam int T      = TICK_WIDTH;

    localparam logic signed [SW-1:0] POS_MAX = SW'({1'b0, {(POS_WIDTH-1){1'b1}}});
    localparam logic signed [SW-1:0] POS_MIN = ~POS_MAX;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_WRAP   = 6'b000010,
        ST_PREP   = 6'b000100,
        ST_CORDIC = 6'b001000,
        ST_MUL    = 6'b010000,
        ST_SUM    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic                        op_reg;
    logic signed [SUM_W-1:0]     fsum_reg, ssum_reg;
    logic signed [HM_W-1:0]      hm_reg;
    logic [DPT_W-1:0]            dpt_reg;
    logic signed [POS_WIDTH-1:0] gx_reg, gy_reg;
    logic                        scl_ok_reg;
    logic                        m_tvalid_reg;
    logic [OUT_DW-1:0]           m_tdata_reg;

    // input beat unpack
    logic signed [T-1:0]      fl, fr, rl, rr;
    logic signed [HEAD_W-1:0] hd;
    logic signed [SUM_W-1:0]  fsum_in, ssum_in;
    logic                     s_acc;

    assign fl      = signed'(s_tdata[T-1:0]);
    assign fr      = signed'(s_tdata[2*T-1:T]);
    assign rl      = signed'(s_tdata[3*T-1:2*T]);
    assign rr      = signed'(s_tdata[4*T-1:3*T]);
    assign hd      = signed'(s_tdata[4*T+HEAD_W-1:4*T]);
    assign fsum_in = SUM_W'(fl) + SUM_W'(fr) + SUM_W'(rl) + SUM_W'(rr);
    assign ssum_in = SUM_W'(fr) + SUM_W'(rl) - SUM_W'(fl) - SUM_W'(rr);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // heading wrap into one turn
    logic hm_neg, hm_big, wrap_ok;
    assign hm_neg  = hm_reg[HM_W-1];
    assign hm_big  = !hm_neg && (hm_reg >= HM_W'(FULL_TURN));
    assign wrap_ok = !hm_neg && !hm_big;

    // sequencing strobes into the serial units
    logic div_start, cordic_start, mul_start;
    logic div_done, cordic_done;
    logic [1:0] scl_done;
    logic [3:0] mul_done;
    logic [ANG_W-1:0] bam;
    logic signed [TRIG_W-1:0] cos_v, sin_v;
    logic signed [FW-1:0] fwd, strafe;
    logic [3:0][PW-1:0] prod;

    assign div_start    = (state_reg == ST_WRAP) && wrap_ok;
    assign cordic_start = (state_reg == ST_PREP) && div_done && scl_ok_reg;
    assign mul_start    = (state_reg == ST_CORDIC) && cordic_done;

    moi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .m       (hm_reg[TURN_W-1:0]),
        .done    (div_done),
        .bam     (bam)
    );

    // wheel sums scaled by distance per tick, units of 2^-26 inch
    moi_mul #(.AW(SUM_W), .BW(SCL_BW)) u_scl_fwd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (fsum_reg),
        .b       ({1'b0, dpt_reg}),
        .done    (scl_done[0]),
        .product (fwd)
    );

    moi_mul #(.AW(SUM_W), .BW(SCL_BW)) u_scl_str (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (ssum_reg),
        .b       ({1'b0, dpt_reg}),
        .done    (scl_done[1]),
        .product (strafe)
    );

    moi_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .bam     (bam),
        .done    (cordic_done),
        .cos_out (cos_v),
        .sin_out (sin_v)
    );

    // rotation lanes: fwd*cos, str*sin, fwd*sin, str*cos
    moi_mul #(.AW(FW), .BW(TRIG_W)) u_mul_fc (
        .aclk (aclk), .aresetn (aresetn), .start (mul_start),
        .a (fwd), .b (cos_v), .done (mul_done[0]), .product (prod[0])
    );
    moi_mul #(.AW(FW), .BW(TRIG_W)) u_mul_ss (
        .aclk (aclk), .aresetn (aresetn), .start (mul_start),
        .a (strafe), .b (sin_v), .done (mul_done[1]), .product (prod[1])
    );
    moi_mul #(.AW(FW), .BW(TRIG_W)) u_mul_fs (
        .aclk (aclk), .aresetn (aresetn), .start (mul_start),
        .a (fwd), .b (sin_v), .done (mul_done[2]), .product (prod[2])
    );
    moi_mul #(.AW(FW), .BW(TRIG_W)) u_mul_sc (
        .aclk (aclk), .aresetn (aresetn), .start (mul_start),
        .a (strafe), .b (cos_v), .done (mul_done[3]), .product (prod[3])
    );

    // floor of each product by 2^30, then round to q.16 and clip
    logic signed [DXW-1:0]       dx, dy, dxr, dyr;
    logic signed [SW-1:0]        sx, sy;
    logic signed [POS_WIDTH-1:0] nx, ny;
    logic                        clip_x, clip_y, sat_new;
    logic                        out_free;

    assign dx  = DXW'(signed'(prod[0][PW-1:FRAC_SHIFT]))
               - DXW'(signed'(prod[1][PW-1:FRAC_SHIFT]));
    assign dy  = DXW'(signed'(prod[2][PW-1:FRAC_SHIFT]))
               + DXW'(signed'(prod[3][PW-1:FRAC_SHIFT]));
    assign dxr = (dx + DXW'(ROUND_BIAS)) >>> ROUND_SHIFT;
    assign dyr = (dy + DXW'(ROUND_BIAS)) >>> ROUND_SHIFT;
    assign sx  = SW'(gx_reg) + SW'(dxr);
    assign sy  = SW'(gy_reg) + SW'(dyr);

    always_comb begin
        clip_x = 1'b0;
        clip_y = 1'b0;
        if (op_reg) begin
            nx = '0;
            ny = '0;
        end else begin
            if (sx > POS_MAX) begin
                nx     = POS_MAX[POS_WIDTH-1:0];
                clip_x = 1'b1;
            end else if (sx < POS_MIN) begin
                nx     = POS_MIN[POS_WIDTH-1:0];
                clip_x = 1'b1;
            end else begin
                nx = sx[POS_WIDTH-1:0];
            end
            if (sy > POS_MAX) begin
                ny     = POS_MAX[POS_WIDTH-1:0];
                clip_y = 1'b1;
            end else if (sy < POS_MIN) begin
                ny     = POS_MIN[POS_WIDTH-1:0];
                clip_y = 1'b1;
            end else begin
                ny = sy[POS_WIDTH-1:0];
            end
        end
    end

    assign sat_new  = clip_x || clip_y;
    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = s_tuser[0] ? ST_SUM : ST_WRAP;
                end
            end
            ST_WRAP: begin
                if (wrap_ok) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (cordic_start) begin
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                if (cordic_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (&mul_done) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            gx_reg       <= '0;
            gy_reg       <= '0;
            dpt_reg      <= DPT_RESET;
            scl_ok_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // register write on the access phase
            if (psel && penable && pwrite && pready && (paddr[2] == REG_DPT)) begin
                dpt_reg <= pwdata[DPT_W-1:0];
            end

            if (s_acc) begin
                op_reg     <= s_tuser[0];
                fsum_reg   <= fsum_in;
                ssum_reg   <= ssum_in;
                hm_reg     <= HM_W'(hd);
                scl_ok_reg <= 1'b0;
            end

            if (state_reg == ST_WRAP) begin
                if (hm_neg) begin
                    hm_reg <= hm_reg + HM_W'(FULL_TURN);
                end else if (hm_big) begin
                    hm_reg <= hm_reg - HM_W'(FULL_TURN);
                end
            end

            if (&scl_done) begin
                scl_ok_reg <= 1'b1;
            end

            // a new result replaces the one taken in the same cycle
            if ((state_reg == ST_SUM) && out_free) begin
                gx_reg       <= nx;
                gy_reg       <= ny;
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= OUT_DW'({sat_new, ny, nx});
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_DPT) ? APB_DW'(dpt_reg) : '0;
endmodule
`default_nettype wire

/* hdl/moi_checker.sv */
// port-level checker for the odometry integrator, bound to the top level
`default_nettype none
`include "mecanum_odometry_integrator_top_defines.svh"
module moi_checker import moi_pkg::*; #(
    parameter int POS_WIDTH = POS_WIDTH_DEF,
    localparam int OUT_DW = ((2*POS_WIDTH + 1 + 7) / 8) * 8
) (
    input wire              aclk,
    input wire              aresetn,
    input wire              s_tvalid,
    input wire              s_tready,
    input wire              m_tvalid,
    input wire              m_tready,
    input wire [OUT_DW-1:0] m_tdata,
    input wire              psel,
    input wire              penable,
    input wire              pwrite,
    input wire              pready,
    input wire [APB_AW-1:0] paddr,
    input wire [APB_DW-1:0] pwdata,
    input wire [APB_DW-1:0] prdata
);
    // one beat at a time: input closes right after an accept
    `MOI_ASSERT_NEXT(a_one_beat, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // reset empties the output register
    `MOI_ASSERT_NEXT_NR(a_rst_empty, aclk, !aresetn, !m_tvalid)
    // a stalled result beat holds
    `MOI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // a register write reads back
    `MOI_ASSERT_NEXT(a_cfg_rb, aclk, aresetn, psel && penable && pwrite && pready && !paddr[2], paddr[2] || (prdata[DPT_W-1:0] == $past(pwdata[DPT_W-1:0])))
endmodule

bind mecanum_odometry_integrator_top moi_checker #(.POS_WIDTH(POS_WIDTH)) u_moi_checker (.*);
`default_nettype wire

/* test/mecanum_odometry_integrator_top_tb.sv */
// self-checking testbench for the mecanum odometry integrator top level
`default_nettype none
module mecanum_odometry_integrator_top_tb;
    import moi_pkg::*;

    localparam int TW     = 16;
    localparam int PW     = 40;
    localparam int IN_DW  = ((4*TW + HEAD_W + 7) / 8) * 8;
    localparam int OUT_DW = ((2*PW + 1 + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SAT_BEATS      = 380;
    localparam logic OP_INTEGRATE = 1'b0;
    localparam logic OP_CLEAR     = 1'b1;

    // wheel motion beat as seen by the predictor
    typedef struct {
        logic                   opcode;
        logic signed [TW-1:0]   fl, fr, rl, rr;
        logic signed [HEAD_W-1:0] heading;
    } wheel_beat_t;

    typedef struct {
        logic signed [PW-1:0] x_pos;
        logic signed [PW-1:0] y_pos;
        logic                 clipped;
    } pose_t;

    // position predictor and store of expected poses
    class odometry_scoreboard;
        logic signed [PW-1:0] pos_x, pos_y;
        logic [DPT_W-1:0]     dist_per_tick;
        pose_t                pending_poses[$];
        int                   mismatches;

        function void reset_state();
            pos_x = '0;
            pos_y = '0;
            dist_per_tick = DPT_RESET;
            pending_poses.delete();
            mismatches = 0;
        endfunction

        // floor(v * t / 2^30) with wide intermediates
        function automatic logic signed [63:0] scale_q30(logic signed [63:0] v,
                                                         logic signed [63:0] t);
            logic signed [127:0] p;
            p = 128'(v) * 128'(t);
            return 64'(p >>> FRAC_SHIFT);
        endfunction

        function automatic void heading_trig(logic signed [HEAD_W-1:0] h,
                                             output logic signed [63:0] c,
                                             output logic signed [63:0] s);
            longint m;
            logic [31:0] ang;
            logic [63:0] wide;
            logic flip;
            logic signed [63:0] z, cx, sy, xs, ys;
            longint arc[CORDIC_STEPS] = '{536870912, 316933406, 167458907, 85004756,
                42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652,
                326, 163, 81};
            m = longint'(h) % FULL_TURN;
            if (m < 0) m += FULL_TURN;
            wide = (64'(m) << 32) / FULL_TURN;
            ang = wide[31:0];
            flip = 1'b0;
            if (ang >= 32'h4000_0000 && ang < 32'hC000_0000) begin
                ang = ang - 32'h8000_0000;
                flip = 1'b1;
            end
            z = 64'(signed'(ang));
            cx = CORDIC_GAIN;
            sy = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = cx >>> i;
                ys = sy >>> i;
                if (z >= 0) begin
                    cx = cx - ys; sy = sy + xs; z = z - arc[i];
                end else begin
                    cx = cx + ys; sy = sy - xs; z = z + arc[i];
                end
            end
            if (flip) begin
                cx = -cx; sy = -sy;
            end
            c = cx;
            s = sy;
        endfunction

        function automatic logic signed [PW-1:0] clip_add(logic signed [PW-1:0] p,
                                                          logic signed [63:0] d,
                                                          inout logic clipped);
            logic signed [65:0] sum;
            logic signed [65:0] hi, lo;
            hi = (66'sd1 <<< (PW-1)) - 1;
            lo = -(66'sd1 <<< (PW-1));
            sum = 66'(p) + 66'(d);
            if (sum > hi) begin clipped = 1'b1; return hi[PW-1:0]; end
            if (sum < lo) begin clipped = 1'b1; return lo[PW-1:0]; end
            return sum[PW-1:0];
        endfunction

        function void note_beat(wheel_beat_t b);
            pose_t e;
            logic signed [63:0] fwd, str, c, s, dx, dy;
            e.clipped = 1'b0;
            if (b.opcode == OP_CLEAR) begin
                pos_x = '0;
                pos_y = '0;
            end else begin
                fwd = (64'(b.fl) + 64'(b.fr) + 64'(b.rl) + 64'(b.rr))
                      * 64'(dist_per_tick);
                str = (-64'(b.fl) + 64'(b.fr) + 64'(b.rl) - 64'(b.rr))
                      * 64'(dist_per_tick);
                heading_trig(b.heading, c, s);
                dx = scale_q30(fwd, c) - scale_q30(str, s);
                dy = scale_q30(fwd, s) + scale_q30(str, c);
                dx = (dx + ROUND_BIAS) >>> ROUND_SHIFT;
                dy = (dy + ROUND_BIAS) >>> ROUND_SHIFT;
                pos_x = clip_add(pos_x, dx, e.clipped);
                pos_y = clip_add(pos_y, dy, e.clipped);
            end
            e.x_pos = pos_x;
            e.y_pos = pos_y;
            pending_poses.push_back(e);
        endfunction

        function void check_pose(logic [OUT_DW-1:0] d);
            pose_t e, a;
            a.x_pos = d[PW-1:0];
            a.y_pos = d[2*PW-1:PW];
            a.clipped = d[2*PW];
            if (pending_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", d);
                return;
            end
            e = pending_poses.pop_front();
            if (a.x_pos !== e.x_pos || a.y_pos !== e.y_pos || a.clipped !== e.clipped) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pose mismatch: exp x=%0d y=%0d sat=%0b got x=%0d y=%0d sat=%0b",
                             e.x_pos, e.y_pos, e.clipped, a.x_pos, a.y_pos, a.clipped);
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    wire                s_tready;
    logic [IN_DW-1:0]   s_tdata = '0;   // fl, fr, rl, rr ticks, heading_centideg
    logic [0:0]         s_tuser = '0;   // opcode
    wire                m_tvalid;
    logic               m_tready = 1'b0;
    wire  [OUT_DW-1:0]  m_tdata;        // x_position, y_position, saturated
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    wire  [APB_DW-1:0]  prdata;
    wire                pready;

    odometry_scoreboard pose_board;
    int  idle_pct = 17;     // set to 0 for a stretch with no idling
    int  quiet_cycles = 0;

    mecanum_odometry_integrator_top dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: random stalls, check every accepted beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) pose_board.check_pose(m_tdata);
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // apb write in setup and access phases
    task automatic write_dpt(logic [DPT_W-1:0] v);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= APB_AW'(4 * REG_DPT); pwdata <= APB_DW'(v);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        pose_board.dist_per_tick = v;
    endtask

    // wait until every pose has come back, then let the block settle
    task automatic drain();
        while (pose_board.pending_poses.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    // one beat on the input channel, with optional idle cycles first
    task automatic send_beat(wheel_beat_t b);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.opcode;
        s_tdata  <= IN_DW'({b.heading, b.rr, b.rl, b.fr, b.fl});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pose_board.note_beat(b);
    endtask

    task automatic send_motion(logic op, int fl, int fr, int rl, int rr, int hd);
        wheel_beat_t b;
        b.opcode = op;
        b.fl = TW'(fl); b.fr = TW'(fr); b.rl = TW'(rl); b.rr = TW'(rr);
        b.heading = HEAD_W'(hd);
        send_beat(b);
    endtask

    function automatic int pick_ticks();
        case ($urandom_range(9))
            0: return -32768;
            1: return 32767;
            2, 3: return $urandom_range(65535) - 32768;
            default: return int'($urandom_range(400)) - 200;
        endcase
    endfunction

    function automatic int pick_heading();
        case ($urandom_range(9))
            0: return int'($urandom_range(131071)) - 65536;   // any 17-bit value
            1: return 9000 * int'($urandom_range(8)) - 36000;
            default: return int'($urandom_range(72000)) - 36000;
        endcase
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(49) == 0)
                send_motion(OP_CLEAR, pick_ticks(), pick_ticks(), pick_ticks(),
                            pick_ticks(), pick_heading());
            else
                send_motion(OP_INTEGRATE, pick_ticks(), pick_ticks(), pick_ticks(),
                            pick_ticks(), pick_heading());
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        pose_board = new();
        pose_board.reset_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: axes, quadrant edges, wrap, extreme ticks, clear
        send_motion(OP_INTEGRATE, 100, 100, 100, 100, 0);
        send_motion(OP_INTEGRATE, -100, 100, 100, -100, 9000);
        send_motion(OP_INTEGRATE, 50, 60, 70, 80, 18000);
        send_motion(OP_INTEGRATE, 50, 60, 70, 80, -18000);
        send_motion(OP_INTEGRATE, 10, 20, 30, 40, 27000);
        send_motion(OP_INTEGRATE, 10, 20, 30, 40, -9000);
        send_motion(OP_INTEGRATE, 1, 2, 3, 4, 36000);
        send_motion(OP_INTEGRATE, 1, 2, 3, 4, -36000);
        send_motion(OP_INTEGRATE, 7, -7, 7, -7, 65535);    // out of range heading
        send_motion(OP_INTEGRATE, 7, -7, 7, -7, -65536);
        send_motion(OP_INTEGRATE, 32767, 32767, 32767, 32767, 4500);
        send_motion(OP_INTEGRATE, -32768, -32768, -32768, -32768, 13500);
        send_motion(OP_INTEGRATE, -32768, 32767, 32767, -32768, 31500);
        send_motion(OP_CLEAR, 32767, -1, -1, -1, -1);
        send_motion(OP_INTEGRATE, 0, 0, 0, 0, 12345);
        s_tvalid <= 1'b0;
        // sender holds off until all poses are back
        drain();

        // largest scale, drive into saturation on both axes, each way
        // about 2^31 q.16 per beat, so a few hundred beats reach the limit
        write_dpt({DPT_W{1'b1}});
        for (int i = 0; i < SAT_BEATS; i++)
            send_motion(OP_INTEGRATE, 32767, 32767, 32767, 32767, 4500);
        send_motion(OP_CLEAR, 0, 0, 0, 0, 0);
        for (int i = 0; i < SAT_BEATS; i++)
            send_motion(OP_INTEGRATE, -32768, -32768, -32768, -32768, 4500);
        random_phase(40);
        drain();

        write_dpt('0);
        random_phase(60);
        drain();

        write_dpt(DPT_W'($urandom()));
        idle_pct = 0;
        random_phase(100);
        idle_pct = 17;
        random_phase(60);
        drain();

        write_dpt(DPT_RESET);
        random_phase(80);
        drain();

        if (pose_board.mismatches == 0 && pose_board.pending_poses.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
+incdir+hdl
hdl/moi_pkg.sv
hdl/moi_mul.sv
hdl/moi_div.sv
hdl/moi_cordic.sv
hdl/mecanum_odometry_integrator_top.sv
hdl/moi_checker.sv
test/mecanum_odometry_integrator_top_tb.sv
